FILE: hdl/prs_pkg.sv
// shared types, codes and constants of the priority round scheduler
package prs_pkg;

  localparam int MAX_PROCS_DEF = 16;
  localparam int PRIO_BITS_DEF = 8;
  localparam int PID_W         = 4;
  localparam int KIND_W        = 3;
  localparam int CFG_W         = 8;
  localparam int PRIO_RST      = 10;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK      = 3'd0,
    KIND_SPAWN     = 3'd1,
    KIND_TERMINATE = 3'd2,
    KIND_SUSPEND   = 3'd3,
    KIND_RESUME    = 3'd4
  } kind_t;

  // slot status codes
  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_READY = 2'd1,
    ST_WAIT  = 2'd2
  } slot_st_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch;
    logic exec;
    logic load;
    logic sort;
    logic finish;
    logic clr_idx;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_tick;
    logic short_q;
    logic idx_last;
  } stat_t;

endpackage

FILE: hdl/prs_ctrl.sv
// sequencing state machine of the priority round scheduler
module prs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  prs_pkg::stat_t stat,
  output prs_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_valid
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_LOAD = 6'b000100,
    S_SORT = 6'b001000,
    S_FIN  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // next state and command decode
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.clr_idx = 1'b1;
        if (!stat.is_tick) begin
          cmd.exec  = 1'b1;
          state_nxt = S_DONE;
        end else if (stat.short_q) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        if (stat.idx_last) begin
          cmd.clr_idx = 1'b1;
          state_nxt   = S_SORT;
        end
      end
      S_SORT: begin
        cmd.sort = 1'b1;
        if (stat.idx_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  // result strobe lasts one cycle
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held");

  // a request is only taken when idle
  a_latch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |-> !busy)
    else $error("request latched while busy");

  // sorting always ends in the finish step
  a_sort_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sort && stat.idx_last) |=> cmd.finish)
    else $error("sort did not end in finish");

endmodule

FILE: hdl/prs_dp.sv
// slot tables, ready queue and sort network of the priority round scheduler
module prs_dp #(
  parameter int MAX_PROCS = prs_pkg::MAX_PROCS_DEF,
  parameter int PRIO_BITS = prs_pkg::PRIO_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  prs_pkg::cmd_t               cmd,
  output prs_pkg::stat_t              stat,
  input  logic [prs_pkg::KIND_W-1:0]  in_kind,
  input  logic [prs_pkg::PID_W-1:0]   in_target_pid,
  input  logic                        cfg_wr_en,
  input  logic [prs_pkg::CFG_W-1:0]   cfg_wr_data,
  output logic [prs_pkg::PID_W-1:0]   out_running_pid,
  output logic                        out_switched,
  output logic [prs_pkg::PID_W-1:0]   out_spawned_pid,
  output logic                        out_spawn_failed
);

  localparam int PW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int KW = PRIO_BITS + 2;
  localparam int SW = (PRIO_BITS > prs_pkg::CFG_W) ? PRIO_BITS : prs_pkg::CFG_W;

  // slot tables and queue
  prs_pkg::slot_st_t    status_r [MAX_PROCS];
  prs_pkg::slot_st_t    status_nxt [MAX_PROCS];
  logic [PRIO_BITS-1:0] prio_r [MAX_PROCS];
  logic [PRIO_BITS-1:0] prio_nxt [MAX_PROCS];
  logic [PRIO_BITS-1:0] dprio_r [MAX_PROCS];
  logic [PRIO_BITS-1:0] dprio_nxt [MAX_PROCS];
  logic [MAX_PROCS-1:0] done_r, done_nxt;
  logic [PW-1:0]        order_r [MAX_PROCS];
  logic [PW-1:0]        order_nxt [MAX_PROCS];
  logic [KW-1:0]        key_r [MAX_PROCS];
  logic [KW-1:0]        key_nxt [MAX_PROCS];
  logic [CW-1:0]        count_r, count_nxt;
  logic [PW-1:0]        running_r, running_nxt;
  logic [PW-1:0]        idx_r, idx_nxt;

  // latched request and results
  logic [prs_pkg::KIND_W-1:0] kind_r;
  logic [prs_pkg::PID_W-1:0]  tgt_r;
  logic [prs_pkg::CFG_W-1:0]  cfg_r;
  logic                       sw_r, sw_nxt;
  logic [PW-1:0]              spawned_r, spawned_nxt;
  logic                       failed_r, failed_nxt;

  // helpers
  logic                 tgt_ok;
  logic [PW-1:0]        tgt_pid;
  logic [SW-1:0]        cfg_ext;
  logic [PRIO_BITS-1:0] spawn_p;
  logic                 free_found;
  logic [PW-1:0]        free_pid;
  logic                 seen;
  logic [PW-1:0]        head;
  logic [PW-1:0]        lpid;

  assign tgt_ok  = (32'(tgt_r) < 32'(MAX_PROCS));
  assign tgt_pid = PW'(tgt_r);
  assign cfg_ext = SW'(cfg_r);
  assign spawn_p = (cfg_ext > SW'({PRIO_BITS{1'b1}})) ? {PRIO_BITS{1'b1}}
                                                       : PRIO_BITS'(cfg_ext);
  assign head    = order_r[0];
  assign lpid    = order_r[idx_r];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_pid   = '0;
    for (int i = MAX_PROCS - 1; i >= 0; i--) begin
      if (status_r[i] == prs_pkg::ST_FREE) begin
        free_found = 1'b1;
        free_pid   = PW'(i);
      end
    end
  end

  // next state of tables
  always_comb begin
    status_nxt  = status_r;
    prio_nxt    = prio_r;
    dprio_nxt   = dprio_r;
    done_nxt    = done_r;
    order_nxt   = order_r;
    key_nxt     = key_r;
    count_nxt   = count_r;
    running_nxt = running_r;
    sw_nxt      = sw_r;
    spawned_nxt = spawned_r;
    failed_nxt  = failed_r;
    idx_nxt     = idx_r + PW'(1);
    seen        = 1'b0;
    if (cmd.clr_idx) begin
      idx_nxt = '0;
    end
    if (cmd.latch) begin
      sw_nxt      = 1'b0;
      spawned_nxt = '0;
      failed_nxt  = 1'b0;
    end
    // non-tick requests, applied in the exec step
    if (cmd.exec) begin
      case (kind_r)
        prs_pkg::KIND_SPAWN: begin
          failed_nxt = !free_found;
          if (free_found) begin
            status_nxt[free_pid] = prs_pkg::ST_READY;
            prio_nxt[free_pid]   = spawn_p;
            dprio_nxt[free_pid]  = spawn_p;
            spawned_nxt          = free_pid;
            if (32'(count_r) < 32'(MAX_PROCS)) begin
              order_nxt[count_r[PW-1:0]] = free_pid;
              done_nxt[free_pid]         = 1'b0;
              count_nxt                  = count_r + CW'(1);
            end
          end
        end
        prs_pkg::KIND_TERMINATE: begin
          if (tgt_ok) begin
            status_nxt[tgt_pid] = prs_pkg::ST_FREE;
            for (int i = 0; i < MAX_PROCS; i++) begin
              if (order_r[i] == tgt_pid && 32'(i) < 32'(count_r)) begin
                seen = 1'b1;
              end
              if (seen && i < MAX_PROCS - 1) begin
                order_nxt[i] = order_r[i+1];
              end
            end
            if (seen) begin
              count_nxt = count_r - CW'(1);
            end
          end
        end
        prs_pkg::KIND_SUSPEND: begin
          if (tgt_ok && status_r[tgt_pid] != prs_pkg::ST_FREE) begin
            status_nxt[tgt_pid] = prs_pkg::ST_WAIT;
          end
        end
        prs_pkg::KIND_RESUME: begin
          if (tgt_ok && status_r[tgt_pid] == prs_pkg::ST_WAIT) begin
            status_nxt[tgt_pid] = prs_pkg::ST_READY;
          end
        end
        default: begin
        end
      endcase
    end
    // gather sort keys one queue entry a cycle
    if (cmd.load) begin
      key_nxt[idx_r] = {status_r[lpid] == prs_pkg::ST_WAIT, done_r[lpid], prio_r[lpid]};
    end
    // odd-even transposition pass, stable on ties
    if (cmd.sort) begin
      for (int i = 0; i < MAX_PROCS - 1; i++) begin
        if ((i % 2) == int'(idx_r[0]) && 32'(i + 1) < 32'(count_r)
            && key_r[i] > key_r[i+1]) begin
          key_nxt[i]     = key_r[i+1];
          key_nxt[i+1]   = key_r[i];
          order_nxt[i]   = order_r[i+1];
          order_nxt[i+1] = order_r[i];
        end
      end
    end
    // round flags, then aging or switch
    if (cmd.finish) begin
      if (key_r[0][PRIO_BITS] || key_r[1][PRIO_BITS]) begin
        done_nxt = '0;
      end
      if (running_r == head) begin
        if (prio_r[head] != {PRIO_BITS{1'b1}}) begin
          prio_nxt[head] = prio_r[head] + PRIO_BITS'(1);
        end
      end else begin
        prio_nxt[running_r] = dprio_r[running_r];
        done_nxt[running_r] = 1'b1;
        running_nxt         = head;
        sw_nxt              = 1'b1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PROCS; i++) begin
        status_r[i] <= (i == 0) ? prs_pkg::ST_READY : prs_pkg::ST_FREE;
        prio_r[i]   <= (i == 0) ? PRIO_BITS'(prs_pkg::PRIO_RST) : '0;
        dprio_r[i]  <= (i == 0) ? PRIO_BITS'(prs_pkg::PRIO_RST) : '0;
        order_r[i]  <= '0;
      end
      done_r    <= '0;
      count_r   <= CW'(1);
      running_r <= '0;
      idx_r     <= '0;
      cfg_r     <= prs_pkg::CFG_W'(prs_pkg::PRIO_RST);
      sw_r      <= 1'b0;
      spawned_r <= '0;
      failed_r  <= 1'b0;
    end else begin
      status_r  <= status_nxt;
      prio_r    <= prio_nxt;
      dprio_r   <= dprio_nxt;
      order_r   <= order_nxt;
      done_r    <= done_nxt;
      count_r   <= count_nxt;
      running_r <= running_nxt;
      idx_r     <= idx_nxt;
      sw_r      <= sw_nxt;
      spawned_r <= spawned_nxt;
      failed_r  <= failed_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
    end
  end

  // request and key registers
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (cmd.latch) begin
      kind_r <= in_kind;
      tgt_r  <= in_target_pid;
    end
  end

  assign stat.is_tick  = (kind_r == prs_pkg::KIND_TICK);
  assign stat.short_q  = (count_r < CW'(2));
  assign stat.idx_last = (idx_r == PW'(MAX_PROCS - 1));

  assign out_running_pid  = prs_pkg::PID_W'(running_r);
  assign out_switched     = sw_r;
  assign out_spawned_pid  = prs_pkg::PID_W'(spawned_r);
  assign out_spawn_failed = failed_r;

  // queue length bounded by the slot count
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(MAX_PROCS))
    else $error("queue overfull");

  // running slot moves only in the finish step
  a_run_fin: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(running_r) |-> $past(cmd.finish))
    else $error("running slot changed outside finish");

  // a switch is always flagged
  a_sw_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && running_r != head) |=> sw_r)
    else $error("switch not flagged");

endmodule

FILE: hdl/priority_round_scheduler.sv
// top level of the priority round scheduler
// sequence: spawn, terminate, suspend, resume and short ticks go from the exec
//   step straight to the result strobe; a sorting tick gathers the keys, runs
//   the odd-even sort passes and then the finish step before the strobe
// throughput: one request at a time, a new one taken the cycle after the strobe
// reset: synchronous active low; slot 0 running at priority ten, queue holds it
module priority_round_scheduler #(
  parameter int MAX_PROCS = prs_pkg::MAX_PROCS_DEF,
  parameter int PRIO_BITS = prs_pkg::PRIO_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [prs_pkg::KIND_W-1:0] in_kind,
  input  logic [prs_pkg::PID_W-1:0]  in_target_pid,
  input  logic                       cfg_wr_en,
  input  logic [prs_pkg::CFG_W-1:0]  cfg_wr_data,
  output logic                       out_valid,
  output logic [prs_pkg::PID_W-1:0]  out_running_pid,
  output logic                       out_switched,
  output logic [prs_pkg::PID_W-1:0]  out_spawned_pid,
  output logic                       out_spawn_failed
);

  prs_pkg::cmd_t  cmd;
  prs_pkg::stat_t stat;

  // sequencer
  prs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // tables and sort
  prs_dp #(
    .MAX_PROCS (MAX_PROCS),
    .PRIO_BITS (PRIO_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_kind          (in_kind),
    .in_target_pid    (in_target_pid),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_running_pid  (out_running_pid),
    .out_switched     (out_switched),
    .out_spawned_pid  (out_spawned_pid),
    .out_spawn_failed (out_spawn_failed)
  );

endmodule
